// ===== sv/cat_pkg.sv =====
// Shared types and constants of the cable amplitude tester.
package cat_pkg;

    localparam int unsigned COUNT_BITS = 16;
    localparam int unsigned LIMIT_BITS = 10;
    localparam int unsigned CFG_INDEX_BITS = 3;
    localparam int unsigned CFG_DATA_BITS = 16;
    localparam int unsigned VERDICT_BITS = 3;

    // External readings at or below this level do not move the external minimum.
    localparam int unsigned EXT_FLOOR = 10;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_COUNT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PASS_LIMIT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RETEST_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FAIL_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GROUND_LIMIT = 3'd4;

    localparam logic [COUNT_BITS-1:0] SAMPLE_COUNT_RESET = 16'd2000;
    localparam logic [LIMIT_BITS-1:0] PASS_LIMIT_RESET = 10'd10;
    localparam logic [LIMIT_BITS-1:0] RETEST_LIMIT_RESET = 10'd20;
    localparam logic [LIMIT_BITS-1:0] FAIL_LIMIT_RESET = 10'd50;
    localparam logic [LIMIT_BITS-1:0] GROUND_LIMIT_RESET = 10'd200;

    localparam logic [VERDICT_BITS-1:0] VERDICT_PASS = 3'd0;
    localparam logic [VERDICT_BITS-1:0] VERDICT_RETEST = 3'd1;
    localparam logic [VERDICT_BITS-1:0] VERDICT_CHECK = 3'd2;
    localparam logic [VERDICT_BITS-1:0] VERDICT_FAIL = 3'd3;
    localparam logic [VERDICT_BITS-1:0] VERDICT_BAD_GROUND = 3'd4;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] pass_limit;
        logic [LIMIT_BITS-1:0] retest_limit;
        logic [LIMIT_BITS-1:0] fail_limit;
        logic [LIMIT_BITS-1:0] ground_limit;
    } limits_t;

endpackage

// ===== sv/cable_amplitude_tester.sv =====
// Top level of the cable amplitude tester.
//
//  Channel  Signals                                          Driven by
//  in       in_valid, mode, internal_sample, ext._sample   source, in_stall by block
//  out      out_valid, verdict, *_amplitude, difference     block, out_stall by sink
//  cfg      cfg_write, cfg_index, cfg_data                  host
//
// One item is accepted per cycle while in_stall is low; the tracker keeps the extremes in registers.
// The sample item that completes the test sets the finish register; the extremes then move to the result register.
// in_stall rises only while a finished test waits and the result register is stalled.
// Reset clears control state and loads the default configuration at once.
module cable_amplitude_tester #(
    parameter int unsigned SAMPLE_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                mode,
    input  logic [SAMPLE_BITS-1:0]              internal_sample,
    input  logic [SAMPLE_BITS-1:0]              external_sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [cat_pkg::VERDICT_BITS-1:0]    verdict,
    output logic [SAMPLE_BITS-1:0]              internal_amplitude,
    output logic [SAMPLE_BITS-1:0]              external_amplitude,
    output logic [SAMPLE_BITS-1:0]              amplitude_difference,
    input  logic                                cfg_write,
    input  logic [cat_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [cat_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    logic [cat_pkg::COUNT_BITS-1:0] sample_count;
    cat_pkg::limits_t               limits;
    logic                           finish;
    logic                           move;
    logic [SAMPLE_BITS-1:0]         internal_max;
    logic [SAMPLE_BITS-1:0]         internal_min;
    logic [SAMPLE_BITS-1:0]         external_max;
    logic [SAMPLE_BITS-1:0]         external_min;

    cat_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_count (sample_count),
        .limits       (limits)
    );

    cat_tracker #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_tracker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .internal_sample (internal_sample),
        .external_sample (external_sample),
        .sample_count    (sample_count),
        .move            (move),
        .finish          (finish),
        .internal_max    (internal_max),
        .internal_min    (internal_min),
        .external_max    (external_max),
        .external_min    (external_min)
    );

    cat_grader #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_grader (
        .clk                  (clk),
        .rst_n                (rst_n),
        .finish               (finish),
        .move                 (move),
        .internal_max         (internal_max),
        .internal_min         (internal_min),
        .external_max         (external_max),
        .external_min         (external_min),
        .limits               (limits),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .verdict              (verdict),
        .internal_amplitude   (internal_amplitude),
        .external_amplitude   (external_amplitude),
        .amplitude_difference (amplitude_difference)
    );

endmodule

// ===== sv/cat_cfg_regs.sv =====
// Configuration registers of the cable amplitude tester.
module cat_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [cat_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [cat_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output logic [cat_pkg::COUNT_BITS-1:0]       sample_count,
    output cat_pkg::limits_t                     limits
);

    logic [cat_pkg::COUNT_BITS-1:0] sample_count_reg;
    cat_pkg::limits_t               limits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= cat_pkg::SAMPLE_COUNT_RESET;
            limits_reg.pass_limit <= cat_pkg::PASS_LIMIT_RESET;
            limits_reg.retest_limit <= cat_pkg::RETEST_LIMIT_RESET;
            limits_reg.fail_limit <= cat_pkg::FAIL_LIMIT_RESET;
            limits_reg.ground_limit <= cat_pkg::GROUND_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                cat_pkg::REG_SAMPLE_COUNT:
                    sample_count_reg <= cfg_data[cat_pkg::COUNT_BITS-1:0];
                cat_pkg::REG_PASS_LIMIT:
                    limits_reg.pass_limit <= cfg_data[cat_pkg::LIMIT_BITS-1:0];
                cat_pkg::REG_RETEST_LIMIT:
                    limits_reg.retest_limit <= cfg_data[cat_pkg::LIMIT_BITS-1:0];
                cat_pkg::REG_FAIL_LIMIT:
                    limits_reg.fail_limit <= cfg_data[cat_pkg::LIMIT_BITS-1:0];
                cat_pkg::REG_GROUND_LIMIT:
                    limits_reg.ground_limit <= cfg_data[cat_pkg::LIMIT_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign sample_count = sample_count_reg;
    assign limits = limits_reg;

endmodule

// ===== sv/cat_tracker.sv =====
// Test sequencing and peak tracking of both sample channels.
module cat_tracker #(
    parameter int unsigned SAMPLE_BITS = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             mode,
    input  logic [SAMPLE_BITS-1:0]           internal_sample,
    input  logic [SAMPLE_BITS-1:0]           external_sample,
    input  logic [cat_pkg::COUNT_BITS-1:0]   sample_count,
    input  logic                             move,
    output logic                             finish,
    output logic [SAMPLE_BITS-1:0]           internal_max,
    output logic [SAMPLE_BITS-1:0]           internal_min,
    output logic [SAMPLE_BITS-1:0]           external_max,
    output logic [SAMPLE_BITS-1:0]           external_min
);

    localparam logic [SAMPLE_BITS-1:0] FLOOR = SAMPLE_BITS'(cat_pkg::EXT_FLOOR);

    logic                            running_reg, running_next;
    logic                            finish_reg, finish_next;
    logic [cat_pkg::COUNT_BITS-1:0]  taken_reg, taken_next;
    logic [SAMPLE_BITS-1:0]          imax_reg, imax_next;
    logic [SAMPLE_BITS-1:0]          imin_reg, imin_next;
    logic [SAMPLE_BITS-1:0]          emax_reg, emax_next;
    logic [SAMPLE_BITS-1:0]          emin_reg, emin_next;
    logic                            accept;

    // A finished test holds the inputs until its extremes move to the result stage.
    assign in_stall = finish_reg && !move;
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        running_next = running_reg;
        finish_next = move ? 1'b0 : finish_reg;
        taken_next = taken_reg;
        imax_next = imax_reg;
        imin_next = imin_reg;
        emax_next = emax_reg;
        emin_next = emin_reg;
        if (accept)
        begin
            if (mode == cat_pkg::MODE_START)
            begin
                running_next = 1'b1;
                taken_next = '0;
                imax_next = '0;
                imin_next = '1;
                emax_next = '0;
                emin_next = '1;
            end
            else if (running_reg)
            begin
                if (internal_sample > imax_reg)
                    imax_next = internal_sample;
                if (internal_sample < imin_reg)
                    imin_next = internal_sample;
                if (external_sample > emax_reg)
                    emax_next = external_sample;
                if (external_sample < emin_reg && external_sample > FLOOR)
                    emin_next = external_sample;
                if (taken_reg != '1)
                    taken_next = taken_reg + 1'b1;
                if (taken_next >= sample_count)
                begin
                    finish_next = 1'b1;
                    running_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            finish_reg <= 1'b0;
            taken_reg <= '0;
            imax_reg <= '0;
            imin_reg <= '1;
            emax_reg <= '0;
            emin_reg <= '1;
        end
        else
        begin
            running_reg <= running_next;
            finish_reg <= finish_next;
            taken_reg <= taken_next;
            imax_reg <= imax_next;
            imin_reg <= imin_next;
            emax_reg <= emax_next;
            emin_reg <= emin_next;
        end
    end

    assign finish = finish_reg;
    assign internal_max = imax_reg;
    assign internal_min = imin_reg;
    assign external_max = emax_reg;
    assign external_min = emin_reg;

    a_finish_not_running: assert property (@(posedge clk) disable iff (!rst_n)
        !(finish_reg && running_reg))
        else $error("finished test still marked running");

    a_fall_ends_test: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(running_reg) |-> finish_reg || $past(accept && mode == cat_pkg::MODE_START))
        else $error("test stopped without a result");

    a_pending_holds: assert property (@(posedge clk) disable iff (!rst_n)
        finish_reg && !move |=> finish_reg && $stable(imax_reg) && $stable(emin_reg))
        else $error("pending extremes changed before transfer");

endmodule

// ===== sv/cat_grader.sv =====
// Amplitude, difference and verdict computation with the result register.
module cat_grader #(
    parameter int unsigned SAMPLE_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                finish,
    output logic                                move,
    input  logic [SAMPLE_BITS-1:0]              internal_max,
    input  logic [SAMPLE_BITS-1:0]              internal_min,
    input  logic [SAMPLE_BITS-1:0]              external_max,
    input  logic [SAMPLE_BITS-1:0]              external_min,
    input  cat_pkg::limits_t                    limits,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [cat_pkg::VERDICT_BITS-1:0]    verdict,
    output logic [SAMPLE_BITS-1:0]              internal_amplitude,
    output logic [SAMPLE_BITS-1:0]              external_amplitude,
    output logic [SAMPLE_BITS-1:0]              amplitude_difference
);

    localparam int unsigned CMP_W =
        (SAMPLE_BITS > cat_pkg::LIMIT_BITS) ? SAMPLE_BITS : cat_pkg::LIMIT_BITS;

    logic                               out_valid_reg, out_valid_next;
    logic [cat_pkg::VERDICT_BITS-1:0]   verdict_reg, verdict_next;
    logic [SAMPLE_BITS-1:0]             amp_i_reg, amp_i_next;
    logic [SAMPLE_BITS-1:0]             amp_e_reg, amp_e_next;
    logic [SAMPLE_BITS-1:0]             diff_reg, diff_next;
    logic [CMP_W-1:0]                   diff_w;
    logic [CMP_W-1:0]                   amp_i_w;

    assign move = finish && (!out_valid_reg || !out_stall);

    always_comb
    begin
        amp_i_next = (internal_max >= internal_min) ? internal_max - internal_min : '0;
        amp_e_next = (external_max >= external_min) ? external_max - external_min : '0;
        diff_next = (amp_i_next >= amp_e_next) ? amp_i_next - amp_e_next
                                               : amp_e_next - amp_i_next;
        diff_w = CMP_W'(diff_next);
        amp_i_w = CMP_W'(amp_i_next);
        if (diff_next == '0)
            verdict_next = (amp_i_w < CMP_W'(limits.ground_limit))
                         ? cat_pkg::VERDICT_BAD_GROUND : cat_pkg::VERDICT_PASS;
        else if (diff_w < CMP_W'(limits.pass_limit))
            verdict_next = cat_pkg::VERDICT_PASS;
        else if (diff_w < CMP_W'(limits.retest_limit))
            verdict_next = cat_pkg::VERDICT_RETEST;
        else if (diff_w <= CMP_W'(limits.fail_limit))
            verdict_next = cat_pkg::VERDICT_CHECK;
        else
            verdict_next = cat_pkg::VERDICT_FAIL;
        out_valid_next = move || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            verdict_reg <= verdict_next;
            amp_i_reg <= amp_i_next;
            amp_e_reg <= amp_e_next;
            diff_reg <= diff_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict = verdict_reg;
    assign internal_amplitude = amp_i_reg;
    assign external_amplitude = amp_e_reg;
    assign amplitude_difference = diff_reg;

    a_diff_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((amp_i_reg >= amp_e_reg) ? (diff_reg == amp_i_reg - amp_e_reg)
                                                    : (diff_reg == amp_e_reg - amp_i_reg)))
        else $error("difference does not match amplitudes");

    a_bad_ground_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && verdict_reg == cat_pkg::VERDICT_BAD_GROUND |-> diff_reg == '0)
        else $error("bad ground reported with nonzero difference");

    a_zero_diff_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && diff_reg == '0 |->
            verdict_reg == cat_pkg::VERDICT_PASS || verdict_reg == cat_pkg::VERDICT_BAD_GROUND)
        else $error("zero difference graded as a mismatch");

endmodule
